// File: sv/fgp_pkg.sv
// Shared types, constants and codes of the FASTA genome packer.
package fgp_pkg;

    localparam int MaxChroms = 1024;
    localparam int PosBits   = 36;
    localparam int MaxShift  = 24;

    localparam logic [7:0] ChGt = 8'h3E;
    localparam logic [7:0] ChCr = 8'h0D;
    localparam logic [7:0] ChLf = 8'h0A;
    localparam logic [7:0] ChSp = 8'h20;
    localparam logic [7:0] ChTab = 8'h09;

    localparam logic [1:0] OP_TEXT  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] K_BASE   = 3'd0;
    localparam logic [2:0] K_NAME   = 3'd1;
    localparam logic [2:0] K_RECORD = 3'd2;
    localparam logic [2:0] K_ANSWER = 3'd3;
    localparam logic [2:0] K_ERROR  = 3'd4;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_EMPTY = 2'd1;
    localparam logic [1:0] E_FULL  = 2'd2;
    localparam logic [1:0] E_NOTAB = 2'd3;

    localparam logic [1:0] M_START = 2'd0;
    localparam logic [1:0] M_SEQ   = 2'd1;
    localparam logic [1:0] M_NAME  = 2'd2;
    localparam logic [1:0] M_REST  = 2'd3;

    localparam logic [0:0] A_PAD_SHIFT = 1'd0;
    localparam logic [0:0] A_SPACING   = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE, S_OUT, S_SCAN, S_SCAN_WAIT, S_ANSWER
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;       // input item accepted while idle
        logic out_pop;    // head result taken
        logic scan_start; // begin table walk
        logic scan_step;  // advance walk
        logic scan_done;  // push query answer
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_out;    // a result waits
        logic is_query;   // accepted item is a query with a table
        logic scan_last;  // walk at final entry
    } t_status;

endpackage

// File: sv/fasta_genome_packer_unit.sv
// Top level of the FASTA genome packer.
// channel  | direction | handshake              | payload
// s_axis   | in        | tvalid/tready          | tdata {query_pos,data_byte,operation}
// m_axis   | out       | tvalid/tready, tlast   | tdata result fields, tuser kind
// apb      | config    | psel/penable, pready=1 | pad_shift @0, spacing_byte @4
// A text byte or end of input gives at most 2 results.
// A query walks the start table one entry a cycle.
// Reset is synchronous; the table needs no clearing. Output stalls hold the item.
module fasta_genome_packer_unit #(
    parameter int MaxChroms = fgp_pkg::MaxChroms,
    parameter int PosBits   = fgp_pkg::PosBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // operation[1:0], data_byte[9:2], query_pos[45:10]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,  // out_byte, position, chrom_index, chrom_start,
                                        // chrom_length, pad_length, error_code
    output logic [2:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import fgp_pkg::*;

    t_cmd w_cmd;
    t_status w_status;
    logic [156:0] w_res;
    logic w_out_valid;

    assign pready = 1'b1;

    fgp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_ready(m_axis_tready), .o_out_valid(w_out_valid),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    fgp_datapath #(.MaxChroms(MaxChroms), .PosBits(PosBits)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_operation(s_axis_tdata[1:0]),
        .i_data_byte(s_axis_tdata[9:2]),
        .i_query_pos(s_axis_tdata[45:10]),
        .i_cfg_we(psel && penable && pwrite),
        .i_cfg_addr(paddr[2]),
        .i_cfg_wdata(pwdata),
        .o_cfg_rdata(prdata),
        .o_result(w_res)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tuser  = w_res[2:0];
    assign m_axis_tdata  = {7'd0, w_res[155:3]};
    assign m_axis_tlast  = w_res[156];
endmodule

// File: sv/fgp_ram.sv
// Generic single-port-write, registered-read RAM.
module fgp_ram #(
    parameter int Width = 36,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: sv/fgp_ctrl.sv
// Controller: item acceptance, result draining and start table walk.
module fgp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  fgp_pkg::t_status i_status,
    output fgp_pkg::t_cmd   o_cmd
);
    import fgp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // results of a text byte or end of input; a query first walks
                if (i_status.is_query) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else if (!i_status.has_out) begin
                    n_state = S_IDLE;
                end else begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) begin
                        o_cmd.out_pop = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                o_cmd.scan_step = 1'b1;
                n_state = S_ANSWER;
            end
            S_ANSWER: begin
                o_cmd.scan_done = 1'b1;
                n_state = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: sv/fgp_datapath.sv
// Datapath: parser state, padding arithmetic, result slots and table walk.
module fgp_datapath #(
    parameter int MaxChroms = fgp_pkg::MaxChroms,
    parameter int PosBits   = fgp_pkg::PosBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fgp_pkg::t_cmd      i_cmd,
    output fgp_pkg::t_status   o_status,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_data_byte,
    input  logic [35:0]        i_query_pos,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    output logic [31:0]        o_cfg_rdata,
    output logic [156:0]       o_result
);
    import fgp_pkg::*;

    localparam int IdxBits = (MaxChroms > 1) ? $clog2(MaxChroms) : 1;
    localparam int CntBits = $clog2(MaxChroms + 1);

    // result layout: last,err,pad,len,start,idx,pos,byte,kind (high first)
    typedef struct packed {
        logic        last;
        logic [1:0]  err;
        logic [24:0] pad;
        logic [35:0] len;
        logic [35:0] start;
        logic [9:0]  idx;
        logic [35:0] pos;
        logic [7:0]  ob;
        logic [2:0]  kind;
    } t_res;

    logic [4:0] r_pad_shift;
    logic [7:0] r_spacing;
    logic [1:0] r_mode;
    logic r_held_cr, r_name_open, r_done;
    logic [PosBits-1:0] r_seq, r_open;
    logic [CntBits-1:0] r_count;

    t_res r_slot0, r_slot1;
    logic r_v0, r_v1, r_query;
    logic [PosBits-1:0] r_q;
    logic [IdxBits-1:0] r_raddr, r_best, r_cmp_idx;
    logic [PosBits-1:0] r_best_start;
    logic r_found, r_cmp_v;

    logic [PosBits-1:0] w_rdata;
    logic w_we;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_shift <= 5'd18;
            r_spacing <= 8'd5;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == A_PAD_SHIFT) r_pad_shift <= i_cfg_wdata[4:0];
            else r_spacing <= i_cfg_wdata[7:0];
        end
    end
    assign o_cfg_rdata = (i_cfg_addr == A_PAD_SHIFT) ? {27'd0, r_pad_shift}
                                                    : {24'd0, r_spacing};

    // close arithmetic
    logic [4:0] w_sh;
    logic [PosBits-1:0] w_blk, w_len, w_rem, w_pad_mid, w_pad_end;
    assign w_sh  = (r_pad_shift > 5'(MaxShift)) ? 5'(MaxShift) : r_pad_shift;
    assign w_blk = PosBits'(1) << w_sh;
    assign w_len = r_seq - r_open;
    assign w_rem = w_len & (w_blk - PosBits'(1));
    assign w_pad_mid = w_blk - w_rem;
    assign w_pad_end = (w_rem != '0) ? w_blk - w_rem : '0;

    logic w_full;
    assign w_full = (r_count >= CntBits'(MaxChroms));

    function automatic t_res mk(input logic [2:0] k, input logic [7:0] b,
                                input logic [1:0] e);
        t_res t;
        t = '0;
        t.kind = k; t.ob = b; t.err = e;
        return t;
    endfunction

    // next parser state and results for one item
    logic [1:0] n_mode;
    logic n_held_cr, n_name_open, n_done;
    logic [PosBits-1:0] n_seq, n_open;
    logic [CntBits-1:0] n_count;
    t_res n_s0, n_s1;
    logic n_v0, n_v1, n_qry;
    logic [7:0] w_c;
    logic w_close, w_at_end;
    t_res w_rec;
    logic [PosBits-1:0] w_pad;

    always_comb begin
        w_at_end = (i_operation == OP_END);
        w_pad = w_at_end ? w_pad_end : w_pad_mid;
        w_rec = '0;
        if (w_full) begin
            w_rec = mk(K_ERROR, 8'd0, E_FULL);
        end else begin
            w_rec.kind = K_RECORD;
            w_rec.ob = r_spacing;
            w_rec.idx = 10'(r_count);
            w_rec.start = 36'(r_open);
            w_rec.len = 36'(w_len);
            w_rec.pad = 25'(w_pad);
        end
    end

    always_comb begin
        n_mode = r_mode; n_held_cr = r_held_cr; n_name_open = r_name_open;
        n_done = r_done; n_seq = r_seq; n_open = r_open; n_count = r_count;
        n_s0 = '0; n_s1 = '0; n_v0 = 1'b0; n_v1 = 1'b0; n_qry = 1'b0;
        w_close = 1'b0;
        w_c = i_data_byte;
        case (i_operation)
            OP_TEXT: begin
                if (!r_done) begin
                    case (r_mode)
                        M_START, M_SEQ: begin
                            if (r_mode == M_START && w_c == ChGt) begin
                                if (r_name_open) begin
                                    w_close = 1'b1;
                                    n_s0 = w_rec; n_v0 = 1'b1;
                                    n_seq = r_seq + w_pad;
                                    n_open = r_seq + w_pad;
                                end else begin
                                    n_open = '0;
                                end
                                n_name_open = 1'b1;
                                n_held_cr = 1'b0;
                                n_mode = M_NAME;
                            end else if (w_c == ChLf) begin
                                n_mode = M_START;
                            end else begin
                                n_mode = M_SEQ;
                                if (!(w_c == ChSp || w_c == ChTab || w_c == 8'h0B
                                      || w_c == 8'h0C || w_c == ChCr)) begin
                                    n_s0 = '0;
                                    n_s0.kind = K_BASE;
                                    n_s0.ob = (w_c >= 8'h61 && w_c <= 8'h7A)
                                              ? w_c - 8'd32 : w_c;
                                    n_s0.pos = 36'(r_seq);
                                    n_v0 = 1'b1;
                                    n_seq = r_seq + PosBits'(1);
                                end
                            end
                        end
                        M_NAME: begin
                            if (w_c == ChLf || w_c == ChSp || w_c == ChTab) begin
                                n_held_cr = 1'b0;
                                n_mode = (w_c == ChLf) ? M_START : M_REST;
                            end else begin
                                if (r_held_cr) begin
                                    n_s0 = mk(K_NAME, ChCr, E_NONE); n_v0 = 1'b1;
                                end
                                if (w_c == ChCr) begin
                                    n_held_cr = 1'b1;
                                end else begin
                                    n_held_cr = 1'b0;
                                    if (r_held_cr) begin
                                        n_s1 = mk(K_NAME, w_c, E_NONE);
                                        n_v1 = 1'b1;
                                    end else begin
                                        n_s0 = mk(K_NAME, w_c, E_NONE);
                                        n_v0 = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (w_c == ChLf) n_mode = M_START;
                        end
                    endcase
                end
            end
            OP_END: begin
                if (!r_done) begin
                    if (r_name_open) begin
                        w_close = 1'b1;
                        n_s0 = w_rec; n_v0 = 1'b1;
                        n_seq = r_seq + w_pad;
                        n_open = r_seq + w_pad;
                    end
                    n_name_open = 1'b0; n_held_cr = 1'b0;
                    n_mode = M_START; n_done = 1'b1;
                    if (n_seq == '0) begin
                        if (n_v0) begin
                            n_s1 = mk(K_ERROR, 8'd0, E_EMPTY); n_v1 = 1'b1;
                        end else begin
                            n_s0 = mk(K_ERROR, 8'd0, E_EMPTY); n_v0 = 1'b1;
                        end
                    end
                end
            end
            OP_QUERY: begin
                if (r_count == '0) begin
                    n_s0 = mk(K_ERROR, 8'd0, E_NOTAB); n_v0 = 1'b1;
                end else begin
                    n_qry = 1'b1;
                end
            end
            default: ;
        endcase
        if (w_close && !w_full) n_count = r_count + CntBits'(1);
        // mark final result
        if (n_v1) n_s1.last = 1'b1;
        else if (n_v0) n_s0.last = 1'b1;
    end

    assign w_we = i_cmd.take && w_close && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START; r_held_cr <= 1'b0; r_name_open <= 1'b0;
            r_done <= 1'b0; r_seq <= '0; r_open <= '0; r_count <= '0;
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_query <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_mode <= n_mode; r_held_cr <= n_held_cr;
                r_name_open <= n_name_open; r_done <= n_done;
                r_seq <= n_seq; r_open <= n_open; r_count <= n_count;
                r_v0 <= n_v0; r_v1 <= n_v1; r_query <= n_qry;
            end else if (i_cmd.out_pop) begin
                r_v0 <= r_v1; r_v1 <= 1'b0;
            end else if (i_cmd.scan_start) begin
                r_query <= 1'b0;
            end else if (i_cmd.scan_done) begin
                r_v0 <= 1'b1;
            end
        end
    end

    // query answer built from the walk result
    t_res w_ans;
    always_comb begin
        w_ans = '0;
        w_ans.kind = K_ANSWER;
        w_ans.pos = 36'(r_q - r_best_start);
        w_ans.idx = 10'(r_best);
        w_ans.start = 36'(r_best_start);
        w_ans.last = 1'b1;
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_slot0 <= n_s0; r_slot1 <= n_s1;
            r_q <= PosBits'(i_query_pos);
        end else if (i_cmd.out_pop) begin
            r_slot0 <= r_slot1;
        end else if (i_cmd.scan_done) begin
            r_slot0 <= w_ans;
        end
    end

    // table walk: one entry per cycle, compare on registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_raddr <= '0; r_cmp_v <= 1'b0; r_found <= 1'b0;
            r_best <= '0; r_best_start <= '0;
        end else if (i_cmd.scan_step) begin
            r_raddr <= r_raddr + IdxBits'(1);
            r_cmp_idx <= r_raddr;
            r_cmp_v <= 1'b1;
            if (r_cmp_v && w_rdata <= r_q &&
                (!r_found || w_rdata >= r_best_start)) begin
                r_best <= r_cmp_idx; r_best_start <= w_rdata; r_found <= 1'b1;
            end
        end
    end

    assign o_status.has_out = r_v0;
    assign o_status.is_query = r_query;
    assign o_status.scan_last =
        (CntBits'(r_raddr) + CntBits'(1) >= r_count);

    fgp_ram #(.Width(PosBits), .Depth(MaxChroms)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[IdxBits-1:0]),
        .i_wdata(r_open),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    assign o_result = {r_slot0.last, r_slot0.err, r_slot0.pad, r_slot0.len,
                       r_slot0.start, r_slot0.idx, r_slot0.pos, r_slot0.ob,
                       r_slot0.kind};
endmodule

// File: sv/fgp_checker.sv
// Port-level checker for the genome packer, bound to the top level.
module fgp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import fgp_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_answer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == K_ANSWER |-> m_axis_tlast)
        else $error("query answer not last");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_ERROR |-> m_axis_tdata[152:151] == 2'd0)
        else $error("error code on non-error result");
endmodule

bind fasta_genome_packer_unit fgp_checker u_fgp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

// File: dv/tb.sv
// Testbench for fasta_genome_packer_unit: FASTA text, end of input and queries vs. predictor.
`timescale 1ns / 100ps

module tb;
    import fgp_pkg::*;

    localparam logic [7:0] ChVt = 8'h0B;
    localparam logic [7:0] ChFf = 8'h0C;
    localparam logic [2:0] RegPadShift = 3'd0;
    localparam logic [2:0] RegSpacing  = 3'd4;
    localparam int CycleLimit = 1500000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [35:0] qpos;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [35:0] position;
        logic [9:0]  index;
        logic [35:0] start;
        logic [35:0] length;
        logic [24:0] pad;
        logic [1:0]  err;
        logic        last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    fasta_genome_packer_unit u_top (.*);

    always #1 i_clk = ~i_clk;

    t_item   pending_items[$];
    t_item   cur_item;
    t_result exp_results[$];
    int      errors = 0;
    int      cycles = 0;

    // packer state as predicted
    logic [4:0]  cfg_shift = 5'd18;
    logic [7:0]  cfg_spacing = 8'd5;
    logic [1:0]  ln_mode = M_START;
    logic        cr_held = 1'b0;
    logic        chrom_open = 1'b0;
    logic [35:0] base_cnt = '0;
    logic [35:0] cur_start = '0;
    int          n_chroms = 0;
    logic [35:0] starts [MaxChroms];
    logic        eof_seen = 1'b0;

    function automatic void push_result(logic [2:0] kind, logic [7:0] b, logic [35:0] p,
                                        logic [9:0] idx, logic [35:0] st, logic [35:0] len,
                                        logic [24:0] pad, logic [1:0] err);
        t_result r;
        r = '{kind, b, p, idx, st, len, pad, err, 1'b0};
        exp_results.insert(exp_results.size(), r);
    endfunction

    function automatic void close_chrom(logic at_end);
        int          sh;
        logic [35:0] blk, len, rem, pad;
        sh  = (cfg_shift > MaxShift) ? MaxShift : cfg_shift;
        blk = 36'd1 << sh;
        len = base_cnt - cur_start;
        rem = len & (blk - 36'd1);
        pad = (at_end && rem == 0) ? 36'd0 : blk - rem;
        if (n_chroms < MaxChroms) begin
            push_result(K_RECORD, cfg_spacing, '0, n_chroms[9:0], cur_start, len, pad[24:0],
                        E_NONE);
            starts[n_chroms] = cur_start;
            n_chroms++;
        end else begin
            push_result(K_ERROR, '0, '0, '0, '0, '0, '0, E_FULL);
        end
        base_cnt  = base_cnt + pad;
        cur_start = base_cnt;
    endfunction

    function automatic void pack_text(logic [7:0] c);
        if (ln_mode == M_START) begin
            if (c == ChLf) return;
            if (c == ChGt) begin
                if (chrom_open) close_chrom(1'b0);
                else cur_start = '0;
                chrom_open = 1'b1;
                cr_held = 1'b0;
                ln_mode = M_NAME;
                return;
            end
            ln_mode = M_SEQ;
        end
        case (ln_mode)
            M_SEQ: begin
                if (c == ChLf) begin
                    ln_mode = M_START;
                end else if (!(c == ChSp || c == ChTab || c == ChVt || c == ChFf ||
                               c == ChCr)) begin
                    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
                    push_result(K_BASE, c, base_cnt, '0, '0, '0, '0, E_NONE);
                    base_cnt = base_cnt + 36'd1;
                end
            end
            M_NAME: begin
                if (c == ChLf || c == ChSp || c == ChTab) begin
                    cr_held = 1'b0;
                    ln_mode = (c == ChLf) ? M_START : M_REST;
                end else begin
                    if (cr_held) push_result(K_NAME, ChCr, '0, '0, '0, '0, '0, E_NONE);
                    cr_held = (c == ChCr);
                    if (c != ChCr) push_result(K_NAME, c, '0, '0, '0, '0, '0, E_NONE);
                end
            end
            default: begin
                if (c == ChLf) ln_mode = M_START;
            end
        endcase
    endfunction

    function automatic void locate_pos(logic [35:0] q);
        int best, i;
        logic found;
        best = 0;
        found = 1'b0;
        if (n_chroms == 0) begin
            push_result(K_ERROR, '0, '0, '0, '0, '0, '0, E_NOTAB);
            return;
        end
        for (i = 0; i < n_chroms; i++) begin
            if (starts[i] <= q && (!found || starts[i] >= starts[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        push_result(K_ANSWER, '0, q - starts[best], best[9:0], starts[best], '0, '0, E_NONE);
    endfunction

    function automatic void predict_item(t_item it);
        int n0;
        n0 = exp_results.size();
        if (it.op == OP_TEXT) begin
            if (!eof_seen) pack_text(it.data);
        end else if (it.op == OP_END) begin
            if (!eof_seen) begin
                if (chrom_open) close_chrom(1'b1);
                chrom_open = 1'b0;
                cr_held = 1'b0;
                ln_mode = M_START;
                eof_seen = 1'b1;
                if (base_cnt == 0) push_result(K_ERROR, '0, '0, '0, '0, '0, '0, E_EMPTY);
            end
        end else if (it.op == OP_QUERY) begin
            locate_pos(it.qpos);
        end
        if (exp_results.size() > n0) exp_results[$].last = 1'b1;
    endfunction

    function automatic logic quiet();
        return cycles >= 4000 && cycles < 9000;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_item(cur_item);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (pending_items.size() > 0 && (quiet() || $urandom_range(0, 99) >= 9)) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tdata <= {2'b00, cur_item.qpos, cur_item.data, cur_item.op};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR @%0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_results.size() == 0) begin
                    report_mismatch("unexpected item, kind", m_axis_tuser, 0);
                end else begin
                    w = exp_results.pop_front();
                    if (m_axis_tuser != w.kind) report_mismatch("kind", m_axis_tuser, w.kind);
                    if (m_axis_tdata[7:0] != w.out_byte)
                        report_mismatch("out_byte", m_axis_tdata[7:0], w.out_byte);
                    if (m_axis_tdata[43:8] != w.position)
                        report_mismatch("position", m_axis_tdata[43:8], w.position);
                    if (m_axis_tdata[53:44] != w.index)
                        report_mismatch("chrom_index", m_axis_tdata[53:44], w.index);
                    if (m_axis_tdata[89:54] != w.start)
                        report_mismatch("chrom_start", m_axis_tdata[89:54], w.start);
                    if (m_axis_tdata[125:90] != w.length)
                        report_mismatch("chrom_length", m_axis_tdata[125:90], w.length);
                    if (m_axis_tdata[150:126] != w.pad)
                        report_mismatch("pad_length", m_axis_tdata[150:126], w.pad);
                    if (m_axis_tdata[152:151] != w.err)
                        report_mismatch("error_code", m_axis_tdata[152:151], w.err);
                    if (m_axis_tlast != w.last) report_mismatch("last", m_axis_tlast, w.last);
                end
            end
            m_axis_tready <= quiet() || $urandom_range(0, 99) >= 9;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("fasta_genome_packer_unit: mismatch");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] op, logic [7:0] b, logic [35:0] q);
        t_item it;
        it = '{op, b, q};
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic add_str(string s);
        foreach (s[i]) add_item(OP_TEXT, s[i], '0);
    endtask

    task automatic add_query();
        logic [35:0] q;
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0 || n_chroms == 0) begin
            q = {4'($urandom_range(0, 15)), $urandom()};
        end else begin
            q = starts[$urandom_range(0, n_chroms - 1)];
            if (pick == 1) q = q + 36'($urandom_range(0, 300));
            else if (pick == 2) q = q - 36'd1;
        end
        add_item(OP_QUERY, 8'($urandom_range(0, 255)), q);
    endtask

    task automatic add_header();
        int n, i;
        add_item(OP_TEXT, ChGt, '0);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) add_item(OP_TEXT, ChCr, '0);
            else if ($urandom_range(0, 5) == 0)
                add_item(OP_TEXT, 8'($urandom_range(14, 255)), '0);
            else add_item(OP_TEXT, 8'($urandom_range(8'h41, 8'h7A)), '0);
        end
        if ($urandom_range(0, 2) == 0) add_item(OP_TEXT, ChCr, '0);
        if ($urandom_range(0, 2) == 0) begin
            add_item(OP_TEXT, $urandom_range(0, 1) ? ChSp : ChTab, '0);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) add_item(OP_TEXT, 8'($urandom_range(0, 255)), '0);
        end
        add_item(OP_TEXT, ChLf, '0);
    endtask

    task automatic add_seq_line();
        int n, i, r;
        string alpha;
        alpha = "ACGTacgtNn";
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) add_item(OP_TEXT, 8'($urandom_range(0, 255)), '0);
            else if (r == 1) add_item(OP_TEXT, ($urandom_range(0, 1)) ? ChSp : ChCr, '0);
            else add_item(OP_TEXT, alpha[$urandom_range(0, 9)], '0);
        end
        add_item(OP_TEXT, ChLf, '0);
    endtask

    task automatic add_fasta(int budget);
        int start_n, r;
        start_n = pending_items.size();
        while (pending_items.size() - start_n < budget) begin
            r = $urandom_range(0, 19);
            if (r < 4) add_header();
            else if (r < 15) add_seq_line();
            else if (r < 17) add_query();
            else if (r == 17) add_item(OP_TEXT, ChLf, '0);
            else if (r == 18)
                add_item(2'd3, 8'($urandom_range(0, 255)), {$urandom(), 4'hF});
            else add_item(OP_TEXT, 8'($urandom_range(0, 255)), '0);
        end
    endtask

    // wait until the block stays idle with nothing pending
    task automatic drain();
        int idle_cnt;
        idle_cnt = 0;
        while (idle_cnt < 12) begin
            @(posedge i_clk);
            if (pending_items.size() > 0 || s_axis_tvalid || exp_results.size() > 0 ||
                !s_axis_tready)
                idle_cnt = 0;
            else
                idle_cnt++;
        end
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == RegPadShift) cfg_shift = value[4:0];
        else cfg_spacing = value[7:0];
    endtask

    initial begin
        int ph;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // empty table queries, unused op, bases before any header, empty name,
        // CR inside a name, trailing CR, whitespace and lower case in sequence
        add_item(OP_QUERY, 8'h00, 36'h0);
        add_item(OP_QUERY, 8'hFF, 36'hFFFFFFFFF);
        add_item(2'd3, 8'hA5, 36'h5A5A5A5A5);
        add_str("ac\tg\n\n");
        add_str(">\n");
        add_item(OP_TEXT, 8'hFF, '0);
        add_item(OP_TEXT, ChLf, '0);
        add_str(">a\rb\r x\n");
        add_str("zT \r\n");
        add_item(OP_QUERY, 8'h00, 36'h0);
        drain();
        write_reg(RegPadShift, 32'd25);
        write_reg(RegSpacing, 32'hFF);
        add_fasta(280);
        drain();
        write_reg(RegPadShift, 32'd0);
        write_reg(RegSpacing, 32'h00);
        add_fasta(280);
        for (ph = 0; ph < 3; ph++) begin
            drain();
            write_reg(RegPadShift, $urandom_range(1, 12));
            write_reg(RegSpacing, $urandom_range(0, 255));
            add_fasta(230);
        end
        drain();
        write_reg(RegPadShift, 32'd24);
        add_seq_line();
        add_item(OP_END, 8'h00, '0);
        add_str(">q\nACGT\n");
        add_item(OP_END, 8'h00, '0);
        repeat (120) add_query();
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("fasta_genome_packer_unit: match");
        end else begin
            $display("fasta_genome_packer_unit: mismatch");
        end
        $finish;
    end

endmodule
